// ----- rtl/vds_pkg.sv -----
// Package for the vector dedup set: item codes, controller states and the result bundle.
// Depends on nothing; every other file of the block imports it.
package vds_pkg;

    localparam int CFG_BITS    = 5;
    localparam int ACTION_BITS = 2;
    localparam int VALUE_BITS  = 64;
    localparam int INDEX_BITS  = 10;
    localparam int POS_BITS    = 4;
    localparam int COUNT_BITS  = 11;

    localparam logic [CFG_BITS-1:0] DEF_VECTOR_WIDTH = 5'd4;

    localparam logic RES_INSERT = 1'b0;
    localparam logic RES_READ   = 1'b1;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_COPY,
        ST_FINISH,
        ST_READ
    } t_state;

    typedef struct packed {
        logic kind;
        logic added;
        logic full;
        logic invalid;
    } t_result;

endpackage

// ----- rtl/vds_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on vds_pkg only by convention; holds no control state.
module vds_ram
    import vds_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/vds_ctrl.sv -----
// Controller of the vector dedup set: staging fill, row-by-row search, append copy and reads.
// Depends on vds_pkg and instantiates vds_ram for the vector store and the staging buffer.
module vds_ctrl
    import vds_pkg::*;
#(
    parameter int CAPACITY     = 1024,
    parameter int MAX_WIDTH    = 16,
    parameter int ELEMENT_BITS = 64,
    localparam int EW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int WB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [ACTION_BITS-1:0]  i_action,
    input  logic [ELEMENT_BITS-1:0] i_element,
    input  logic [INDEX_BITS-1:0]   i_entry_index,
    input  logic [POS_BITS-1:0]     i_element_position,
    input  logic                    i_cfg_we,
    input  logic [WW-1:0]           i_width,
    output logic                    o_busy,
    output logic                    o_res_valid,
    output t_result                 o_res,
    output logic [CW-1:0]           o_res_count,
    output logic [ELEMENT_BITS-1:0] o_res_value
);

    localparam int AW = EW + WB;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [WW-1:0] r_fill, n_fill;
    logic [EW-1:0] r_e, n_e;
    logic [WB-1:0] r_p, n_p;
    logic r_cmp_v, n_cmp_v;
    logic r_cmp_first, n_cmp_first;
    logic r_cmp_last, n_cmp_last;
    logic r_row_ok, n_row_ok;
    logic r_cp_v, n_cp_v;
    logic [WB-1:0] r_cp_p, n_cp_p;
    logic r_cp_zero, n_cp_zero;
    logic r_rd_invalid, n_rd_invalid;
    logic r_res_valid, n_res_valid;
    t_result r_res, n_res;
    logic [CW-1:0] r_res_count, n_res_count;
    logic [ELEMENT_BITS-1:0] r_res_value, n_res_value;

    logic [AW-1:0] store_raddr;
    logic store_we;
    logic [AW-1:0] store_waddr;
    logic [ELEMENT_BITS-1:0] store_wdata;
    logic [ELEMENT_BITS-1:0] store_rdata;
    logic stage_we;
    logic [WB-1:0] stage_waddr;
    logic [WB-1:0] stage_raddr;
    logic [ELEMENT_BITS-1:0] stage_rdata;

    t_action action;
    logic add_complete;
    logic row_ok_new;
    logic hit;
    logic p_last;
    logic issue_last;
    logic store_full;

    assign action       = t_action'(i_action);
    assign add_complete = (WW'(r_fill) + WW'(1)) >= i_width;
    assign row_ok_new   = (r_cmp_first | r_row_ok) & (store_rdata == stage_rdata);
    assign hit          = r_cmp_v & r_cmp_last & row_ok_new;
    assign p_last       = (WW'(r_p) + WW'(1)) == i_width;
    assign issue_last   = p_last && ((CW'(r_e) + CW'(1)) == r_count);
    assign store_full   = 32'(r_count) >= CAPACITY;

    vds_ram #(
        .DEPTH (CAPACITY << WB),
        .WIDTH (ELEMENT_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    vds_ram #(
        .DEPTH (1 << WB),
        .WIDTH (ELEMENT_BITS)
    ) u_stage (
        .i_clk   (i_clk),
        .i_we    (stage_we),
        .i_waddr (stage_waddr),
        .i_wdata (i_element),
        .i_raddr (stage_raddr),
        .o_rdata (stage_rdata)
    );

    assign store_we    = r_cp_v;
    assign store_waddr = {EW'(r_count), r_cp_p};
    assign store_wdata = r_cp_zero ? '0 : stage_rdata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    case (action)
                        ACT_ADD: begin
                            if (add_complete) begin
                                n_state = (r_count == '0) ? ST_COPY : ST_SEARCH;
                            end
                        end
                        ACT_READ: n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    n_state = ST_IDLE;
                end else if (issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = (hit || store_full) ? ST_IDLE : ST_COPY;
            end
            ST_COPY: begin
                if (r_p == WB'(MAX_WIDTH - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            ST_READ:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_fill       = r_fill;
        n_e          = r_e;
        n_p          = r_p;
        n_cmp_v      = 1'b0;
        n_cmp_first  = r_cmp_first;
        n_cmp_last   = r_cmp_last;
        n_row_ok     = r_row_ok;
        n_cp_v       = 1'b0;
        n_cp_p       = r_cp_p;
        n_cp_zero    = r_cp_zero;
        n_rd_invalid = r_rd_invalid;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        n_res_count  = r_res_count;
        n_res_value  = r_res_value;
        store_raddr  = {r_e, r_p};
        stage_we     = 1'b0;
        stage_waddr  = WB'(r_fill);
        stage_raddr  = r_p;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    case (action)
                        ACT_ADD: begin
                            stage_we = 1'b1;
                            n_fill   = add_complete ? '0 : r_fill + WW'(1);
                            n_e      = '0;
                            n_p      = '0;
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_fill  = '0;
                        end
                        ACT_READ: begin
                            store_raddr  = {EW'(i_entry_index), WB'(i_element_position)};
                            n_rd_invalid = !((32'(i_entry_index) < 32'(r_count)) &&
                                             (32'(i_element_position) < MAX_WIDTH));
                        end
                        default: begin
                            n_fill = r_fill;
                        end
                    endcase
                end
                if (i_cfg_we) begin
                    n_fill = '0;
                end
            end
            ST_SEARCH: begin
                n_cmp_v     = !hit;
                n_cmp_first = (r_p == '0);
                n_cmp_last  = p_last;
                if (r_cmp_v) begin
                    n_row_ok = row_ok_new;
                end
                if (p_last) begin
                    n_p = '0;
                    n_e = r_e + EW'(1);
                end else begin
                    n_p = r_p + WB'(1);
                end
                if (hit) begin
                    n_res_valid = 1'b1;
                    n_res       = '{kind: RES_INSERT, added: 1'b0, full: 1'b0, invalid: 1'b0};
                    n_res_count = r_count;
                    n_res_value = '0;
                end
            end
            ST_DRAIN: begin
                n_p = '0;
                if (hit || store_full) begin
                    n_res_valid = 1'b1;
                    n_res       = '{kind: RES_INSERT, added: 1'b0, full: !hit,
                                    invalid: 1'b0};
                    n_res_count = r_count;
                    n_res_value = '0;
                end
            end
            ST_COPY: begin
                n_cp_v    = 1'b1;
                n_cp_p    = r_p;
                n_cp_zero = WW'(r_p) >= i_width;
                n_p       = r_p + WB'(1);
            end
            ST_FINISH: begin
                n_count     = r_count + CW'(1);
                n_res_valid = 1'b1;
                n_res       = '{kind: RES_INSERT, added: 1'b1, full: 1'b0, invalid: 1'b0};
                n_res_count = r_count + CW'(1);
                n_res_value = '0;
            end
            ST_READ: begin
                n_res_valid = 1'b1;
                n_res       = '{kind: RES_READ, added: 1'b0, full: 1'b0,
                                invalid: r_rd_invalid};
                n_res_count = r_count;
                n_res_value = r_rd_invalid ? '0 : store_rdata;
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_fill      <= '0;
            r_cmp_v     <= 1'b0;
            r_cp_v      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_cmp_v     <= n_cmp_v;
            r_cp_v      <= n_cp_v;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e          <= n_e;
        r_p          <= n_p;
        r_cmp_first  <= n_cmp_first;
        r_cmp_last   <= n_cmp_last;
        r_row_ok     <= n_row_ok;
        r_cp_p       <= n_cp_p;
        r_cp_zero    <= n_cp_zero;
        r_rd_invalid <= n_rd_invalid;
        r_res        <= n_res;
        r_res_count  <= n_res_count;
        r_res_value  <= n_res_value;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_res_count = r_res_count;
    assign o_res_value = r_res_value;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("Stored count exceeds capacity.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fill < i_width))
        else $error("Staging fill reached the vector width while idle.");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_we |-> (r_state == ST_COPY || r_state == ST_FINISH))
        else $error("Store written outside the append copy.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> ($past(r_state) != ST_IDLE))
        else $error("Result raised without work in progress.");

    a_outcome_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_res.added && r_res.full))
        else $error("Insert outcome both added and full.");

endmodule

// ----- rtl/vector_dedup_set_insert.sv -----
// Top level of the vector dedup set: width register, effective width clamp and port mapping.
// Depends on vds_pkg and instantiates vds_ctrl (which holds the store and staging RAMs).
// Throughput: while busy is low, partial adds and clears are taken one per cycle with no result;
// a read holds busy for one cycle. A completing add searches the stored rows (no search when
// empty) and, if new and not full, appends a row of MAX_WIDTH elements. The result strobe is
// high in the first cycle with busy low and cannot be held off. Reset clears the count and the
// staging fill and sets the width to 4; memories are not swept.
module vector_dedup_set_insert
    import vds_pkg::*;
#(
    parameter int CAPACITY     = 1024,
    parameter int MAX_WIDTH    = 16,
    parameter int ELEMENT_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ACTION_BITS-1:0]       i_action,
    input  logic signed [VALUE_BITS-1:0] i_element_value,
    input  logic [INDEX_BITS-1:0]        i_entry_index,
    input  logic [POS_BITS-1:0]          i_element_position,
    input  logic                         i_cfg_we,
    input  logic [CFG_BITS-1:0]          i_cfg_wdata,
    output logic                         o_result_valid,
    output logic                         o_result_kind,
    output logic                         o_was_added,
    output logic                         o_store_full,
    output logic [COUNT_BITS-1:0]        o_set_count,
    output logic signed [VALUE_BITS-1:0] o_read_value,
    output logic                         o_read_invalid
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CFG_BITS-1:0] r_vector_width;
    logic [WW-1:0] eff_width;
    logic accept;
    t_result res;
    logic [CW-1:0] res_count;
    logic [ELEMENT_BITS-1:0] res_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_width <= DEF_VECTOR_WIDTH;
        end else if (i_cfg_we) begin
            r_vector_width <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_vector_width == '0) begin
            eff_width = WW'(1);
        end else if (32'(r_vector_width) > MAX_WIDTH) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = WW'(r_vector_width);
        end
    end

    assign accept = start && !busy;

    vds_ctrl #(
        .CAPACITY     (CAPACITY),
        .MAX_WIDTH    (MAX_WIDTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_action           (i_action),
        .i_element          (i_element_value[ELEMENT_BITS-1:0]),
        .i_entry_index      (i_entry_index),
        .i_element_position (i_element_position),
        .i_cfg_we           (i_cfg_we),
        .i_width            (eff_width),
        .o_busy             (busy),
        .o_res_valid        (o_result_valid),
        .o_res              (res),
        .o_res_count        (res_count),
        .o_res_value        (res_value)
    );

    assign o_result_kind  = res.kind;
    assign o_was_added    = res.added;
    assign o_store_full   = res.full;
    assign o_read_invalid = res.invalid;
    assign o_set_count    = COUNT_BITS'(res_count);
    assign o_read_value   = VALUE_BITS'($signed(res_value));

endmodule

// ----- dv/tb_vector_dedup_set_insert.sv -----
// Self-checking testbench for vector_dedup_set_insert: directed and random item traffic.
// It carries its own prediction of the set and checks every result strobe against it.
// Depends on vds_pkg and the RTL of the block only.
module tb_vector_dedup_set_insert;
    import vds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = 1024;
    localparam int MAX_WIDTH     = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 100000;
    localparam int PHASE_ITEMS   = 8;
    localparam int CROWD_LIMIT   = 40;

    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
    localparam logic [VALUE_BITS-1:0]  VAL_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_BITS-1:0]  VAL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_BITS-1:0]  VAL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic                  kind;
        logic                  added;
        logic                  full;
        logic [COUNT_BITS-1:0] count;
        logic [VALUE_BITS-1:0] value;
        logic                  invalid;
    } t_set_response;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [ACTION_BITS-1:0]       i_action;
    logic signed [VALUE_BITS-1:0] i_element_value;
    logic [INDEX_BITS-1:0]        i_entry_index;
    logic [POS_BITS-1:0]          i_element_position;
    logic                         i_cfg_we;
    logic [CFG_BITS-1:0]          i_cfg_wdata;
    logic                         o_result_valid;
    logic                         o_result_kind;
    logic                         o_was_added;
    logic                         o_store_full;
    logic [COUNT_BITS-1:0]        o_set_count;
    logic signed [VALUE_BITS-1:0] o_read_value;
    logic                         o_read_invalid;

    logic [VALUE_BITS-1:0] stored_vectors [CAPACITY][MAX_WIDTH];
    logic [VALUE_BITS-1:0] staged [MAX_WIDTH];
    int                    stage_fill;
    int                    held;
    logic [CFG_BITS-1:0]   width_reg;

    t_set_response pending_responses [$];

    int  fail_count;
    int  items_sent;
    int  results_seen;
    int  widths_written;
    int  n_added;
    int  n_dups;
    int  n_full;
    int  n_reads;
    int  n_bad_reads;
    bit  gaps_on;

    vector_dedup_set_insert dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_element_value    (i_element_value),
        .i_entry_index      (i_entry_index),
        .i_element_position (i_element_position),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_result_valid     (o_result_valid),
        .o_result_kind      (o_result_kind),
        .o_was_added        (o_was_added),
        .o_store_full       (o_store_full),
        .o_set_count        (o_set_count),
        .o_read_value       (o_read_value),
        .o_read_invalid     (o_read_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int active_width();
        if (width_reg < 1) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_BITS-1:0] pool_value();
        case ($urandom_range(5))
            0: return '0;
            1: return 64'd1;
            2: return VAL_ONES;
            3: return VAL_MIN;
            4: return VAL_MAX;
            default: return 64'd2;
        endcase
    endfunction

    // Applies one accepted item to the predicted set and queues the result it causes, if any.
    task automatic predict_set_item(input logic [ACTION_BITS-1:0] act,
                                    input logic [VALUE_BITS-1:0] val,
                                    input logic [INDEX_BITS-1:0] idx,
                                    input logic [POS_BITS-1:0] pos);
        t_set_response r;
        int            w;
        bit            found;
        bit            same;
        r = '{kind: RES_INSERT, added: 1'b0, full: 1'b0, count: '0, value: '0, invalid: 1'b0};
        case (act)
            ACT_ADD: begin
                w = active_width();
                staged[stage_fill] = val;
                stage_fill++;
                if (stage_fill >= w) begin
                    stage_fill = 0;
                    found = 1'b0;
                    for (int e = 0; e < held && !found; e++) begin
                        same = 1'b1;
                        for (int p = 0; p < w; p++)
                            if (stored_vectors[e][p] !== staged[p]) same = 1'b0;
                        found = same;
                    end
                    if (found) begin
                        n_dups++;
                    end else if (held >= CAPACITY) begin
                        r.full = 1'b1;
                        n_full++;
                    end else begin
                        for (int p = 0; p < MAX_WIDTH; p++)
                            stored_vectors[held][p] = (p < w) ? staged[p] : '0;
                        held++;
                        r.added = 1'b1;
                        n_added++;
                    end
                    r.count = COUNT_BITS'(held);
                    pending_responses = {pending_responses, r};
                end
            end
            ACT_CLEAR: begin
                held = 0;
                stage_fill = 0;
            end
            ACT_READ: begin
                r.kind = RES_READ;
                r.count = COUNT_BITS'(held);
                n_reads++;
                if (int'(idx) < held) begin
                    r.value = stored_vectors[idx][pos];
                end else begin
                    r.invalid = 1'b1;
                    n_bad_reads++;
                end
                pending_responses = {pending_responses, r};
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [ACTION_BITS-1:0] act,
                             input logic [VALUE_BITS-1:0] val,
                             input logic [INDEX_BITS-1:0] idx,
                             input logic [POS_BITS-1:0] pos);
        if (gaps_on && $urandom_range(99) < 17) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_action           <= act;
        i_element_value    <= val;
        i_entry_index      <= idx;
        i_element_position <= pos;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        items_sent++;
        predict_set_item(act, val, idx, pos);
    endtask

    task automatic send_add(input logic [VALUE_BITS-1:0] val);
        send_item(ACT_ADD, val, INDEX_BITS'($urandom), POS_BITS'($urandom));
    endtask

    task automatic send_read(input logic [INDEX_BITS-1:0] idx, input logic [POS_BITS-1:0] pos);
        send_item(ACT_READ, rand64(), idx, pos);
    endtask

    task automatic send_clear();
        send_item(ACT_CLEAR, rand64(), INDEX_BITS'($urandom), POS_BITS'($urandom));
    endtask

    task automatic wait_set_quiet();
        start <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_vector_width(input logic [CFG_BITS-1:0] w);
        wait_set_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_reg = w;
        stage_fill = 0;
        widths_written++;
    endtask

    task automatic send_random_vector();
        int                    w;
        int                    mode;
        int                    src;
        logic [VALUE_BITS-1:0] v;
        w = active_width();
        mode = $urandom_range(99);
        src = (held > 0) ? $urandom_range(held - 1) : 0;
        for (int p = 0; p < w; p++) begin
            if (mode < 35 && held > 0) v = stored_vectors[src][p];
            else if (mode < 70) v = pool_value();
            else v = rand64();
            send_add(v);
        end
    endtask

    task automatic test_insert_and_duplicate();
        for (int pass = 0; pass < 2; pass++) begin
            send_add(VAL_MIN);
            send_add(VAL_MAX);
            send_add('0);
            send_add(VAL_ONES);
        end
    endtask

    task automatic test_read_back();
        send_read(10'd0, 4'd0);
        send_read(10'd0, 4'd3);
        send_read(10'd0, 4'd15);
        send_read(10'd1, 4'd0);
    endtask

    // A width write drops the partial vector; width 0 behaves as width 1.
    task automatic test_width_register();
        send_add(rand64());
        send_add(rand64());
        write_vector_width(5'd0);
        send_add(VAL_MIN);
        send_add(64'd7);
        write_vector_width(DEF_VECTOR_WIDTH);
    endtask

    task automatic test_clear_and_unused();
        send_add(rand64());
        send_item(ACT_UNUSED, rand64(), INDEX_BITS'($urandom), POS_BITS'($urandom));
        send_clear();
        send_read(10'd0, 4'd0);
        send_add(VAL_MIN);
        send_add(VAL_MAX);
        send_add('0);
        send_add(VAL_ONES);
    endtask

    task automatic test_full_store();
        logic [31:0] tag;
        gaps_on = 1'b0;
        write_vector_width(5'd1);
        send_clear();
        tag = $urandom;
        for (int k = 0; k < CAPACITY; k++)
            send_add({tag, 22'd0, 10'(k)});
        send_add({tag, 22'h3F_FFFF, 10'd0});
        send_add({tag, 22'd0, 10'd1023});
        send_read(10'd1023, 4'd0);
        send_read(10'd1023, 4'd15);
        send_read(INDEX_BITS'($urandom), POS_BITS'($urandom));
        send_clear();
        wait_set_quiet();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [CFG_BITS-1:0] w;
        int                  first;
        int                  r;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: w = 5'd2;
                1: w = 5'd31;
                2: w = 5'd16;
                3: w = 5'd1;
                4: w = CFG_BITS'($urandom_range(17, 30));
                default: w = CFG_BITS'($urandom_range(0, 8));
            endcase
            write_vector_width(w);
            gaps_on = (phase != 3);
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS) begin
                if (held > CROWD_LIMIT) send_clear();
                r = $urandom_range(99);
                if (r < 70) begin
                    send_random_vector();
                end else if (r < 88) begin
                    if (held > 0 && $urandom_range(4) != 0)
                        send_read(INDEX_BITS'($urandom_range(held - 1)), POS_BITS'($urandom));
                    else
                        send_read(INDEX_BITS'($urandom), POS_BITS'($urandom));
                end else if (r < 92) begin
                    repeat ($urandom_range(1, active_width())) send_add(rand64());
                end else if (r < 94) begin
                    send_clear();
                end else if (r < 96) begin
                    send_item(ACT_UNUSED, rand64(), INDEX_BITS'($urandom), POS_BITS'($urandom));
                end else if (r < 97) begin
                    wait_set_quiet();
                end else begin
                    send_add(pool_value());
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [VALUE_BITS-1:0] want,
                               input logic [VALUE_BITS-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_set_response want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            results_seen++;
            if (pending_responses.size() == 0) begin
                $error("result strobe with no item waiting for one");
                fail_count++;
            end else begin
                want = pending_responses.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(o_result_kind));
                check_field("was_added", 64'(want.added), 64'(o_was_added));
                check_field("store_full", 64'(want.full), 64'(o_store_full));
                check_field("set_count", 64'(want.count), 64'(o_set_count));
                check_field("read_value", want.value, o_read_value);
                check_field("read_invalid", 64'(want.invalid), 64'(o_read_invalid));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $error("no item or result moved for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        widths_written = 0;
        n_added = 0;
        n_dups = 0;
        n_full = 0;
        n_reads = 0;
        n_bad_reads = 0;
        gaps_on = 1'b1;
        held = 0;
        stage_fill = 0;
        width_reg = DEF_VECTOR_WIDTH;
        i_rst_n            <= 1'b0;
        start              <= 1'b0;
        i_action           <= ACT_ADD;
        i_element_value    <= '0;
        i_entry_index      <= '0;
        i_element_position <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= DEF_VECTOR_WIDTH;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_insert_and_duplicate();
        test_read_back();
        test_width_register();
        test_clear_and_unused();
        test_full_store();
        test_random_traffic();

        wait_set_quiet();
        repeat (MAX_WIDTH + SETTLE_CYCLES) @(posedge i_clk);
        if (pending_responses.size() != 0) begin
            $error("%0d expected results never arrived", pending_responses.size());
            fail_count++;
        end
        $display("Sent %0d items over %0d width settings; %0d results checked.",
                 items_sent, widths_written, results_seen);
        $display("Vectors stored %0d, duplicates %0d, full drops %0d, reads %0d (%0d invalid).",
                 n_added, n_dups, n_full, n_reads, n_bad_reads);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- vector_dedup_set_insert.f -----
rtl/vds_pkg.sv
rtl/vds_ram.sv
rtl/vds_ctrl.sv
rtl/vector_dedup_set_insert.sv
dv/tb_vector_dedup_set_insert.sv
